// ----- sv/three_axis_velocity_slew_limiter_core_defines.svh -----
// Assertion macros for the velocity slew limiter.
`ifndef THREE_AXIS_VELOCITY_SLEW_LIMITER_CORE_DEFINES_SVH
`define THREE_AXIS_VELOCITY_SLEW_LIMITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TAVSL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TAVSL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TAVSL_ASSERT(name, prop, msg)
`define TAVSL_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- sv/tavsl_pkg.sv -----
// Shared types and constants of the velocity slew limiter.
package tavsl_pkg;

  localparam int VEL_W      = 16;
  localparam int STEP_W     = 15;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TDATA_W    = 3 * VEL_W;

  localparam logic [STEP_W-1:0] LINEAR_STEP_RST  = STEP_W'(51);
  localparam logic [STEP_W-1:0] ANGULAR_STEP_RST = STEP_W'(102);
  localparam logic [CNT_W-1:0]  TIMEOUT_RST      = CNT_W'(2);

  localparam logic MODE_CMD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINEAR_STEP  = 2'd0,
    CFG_ANGULAR_STEP = 2'd1,
    CFG_TIMEOUT      = 2'd2
  } cfg_idx_e;

  typedef logic signed [VEL_W-1:0] vel_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic expire;
  } lane_ctl_t;

endpackage

// ----- sv/tavsl_timer.sv -----
// Saturating tick counter and timeout detect, drives lane control.
module tavsl_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          mode_i,
  input  logic [tavsl_pkg::CNT_W-1:0]   timeout_i,
  output tavsl_pkg::lane_ctl_t          ctl_o
);
  import tavsl_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic             load, tick;

  assign load    = accept_i && (mode_i == MODE_CMD);
  assign tick    = accept_i && (mode_i == MODE_TICK);
  assign cnt_inc = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + CNT_W'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = '0;
    end else if (tick) begin
      cnt_d = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign ctl_o.load   = load;
  assign ctl_o.tick   = tick;
  assign ctl_o.expire = tick && (cnt_inc > timeout_i);

endmodule

// ----- sv/tavsl_lane.sv -----
// One axis: target and current registers with step clamp.
module tavsl_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tavsl_pkg::lane_ctl_t          ctl_i,
  input  tavsl_pkg::vel_t               cmd_i,
  input  logic [tavsl_pkg::STEP_W-1:0]  step_i,
  output tavsl_pkg::vel_t               cur_next_o
);
  import tavsl_pkg::*;

  vel_t                tgt_q, tgt_d, cur_q, cur_d, tgt_eff;
  logic signed [VEL_W:0] diff, lim, clamped, sum;

  assign tgt_eff = ctl_i.expire ? vel_t'(0) : tgt_q;
  assign diff    = {tgt_eff[VEL_W-1], tgt_eff} - {cur_q[VEL_W-1], cur_q};
  assign lim     = $signed({2'b00, step_i});

  always_comb begin
    if (diff > lim) begin
      clamped = lim;
    end else if (diff < -lim) begin
      clamped = -lim;
    end else begin
      clamped = diff;
    end
  end

  assign sum = {cur_q[VEL_W-1], cur_q} + clamped;

  always_comb begin
    tgt_d = tgt_q;
    cur_d = cur_q;
    if (ctl_i.load) begin
      tgt_d = cmd_i;
    end else if (ctl_i.tick) begin
      tgt_d = tgt_eff;
      cur_d = sum[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
      cur_q <= '0;
    end else begin
      tgt_q <= tgt_d;
      cur_q <= cur_d;
    end
  end

  assign cur_next_o = cur_d;

endmodule

// ----- sv/tavsl_merge.sv -----
// Output stage: packs the three lane values into one registered request.
module tavsl_merge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  tavsl_pkg::vel_t                 lin_x_i,
  input  tavsl_pkg::vel_t                 lin_y_i,
  input  tavsl_pkg::vel_t                 ang_z_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [tavsl_pkg::TDATA_W-1:0]   data_o
);
  import tavsl_pkg::*;

  logic               valid_q, valid_d;
  logic [TDATA_W-1:0] data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {ang_z_i, lin_y_i, lin_x_i};
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- sv/three_axis_velocity_slew_limiter_core.sv -----
// Top level of the three-axis velocity slew limiter.
// A tick request shows its result on m_axis in the cycle after acceptance.
// Throughput: one request per cycle, commands and ticks alike.
// The single output register sets this; input stalls only while it is full and held.
// Reset clears targets, currents and tick counter to zero.
// Reset loads step limits 51 and 102 and a timeout of 2 ticks.
`include "three_axis_velocity_slew_limiter_core_defines.svh"
module three_axis_velocity_slew_limiter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tavsl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tavsl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // cmd_linear_x [15:0], cmd_linear_y [31:16], cmd_angular_z [47:32]
  input  logic [tavsl_pkg::TDATA_W-1:0]     s_axis_tdata_i,
  // mode [0]
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_linear_x [15:0], out_linear_y [31:16], out_angular_z [47:32]
  output logic [tavsl_pkg::TDATA_W-1:0]     m_axis_tdata_o
);
  import tavsl_pkg::*;

  logic [STEP_W-1:0] lin_step_q, ang_step_q;
  logic [CNT_W-1:0]  timeout_q;
  logic              accept;
  lane_ctl_t         ctl;
  vel_t              nx, ny, nz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_step_q <= LINEAR_STEP_RST;
      ang_step_q <= ANGULAR_STEP_RST;
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINEAR_STEP:  lin_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_ANGULAR_STEP: ang_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_TIMEOUT:      timeout_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !m_axis_tvalid_o || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  tavsl_timer u_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .mode_i    (s_axis_tuser_i),
    .timeout_i (timeout_q),
    .ctl_o     (ctl)
  );

  tavsl_lane u_lane_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .cmd_i      (s_axis_tdata_i[VEL_W-1:0]),
    .step_i     (lin_step_q),
    .cur_next_o (nx)
  );

  tavsl_lane u_lane_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .cmd_i      (s_axis_tdata_i[2*VEL_W-1:VEL_W]),
    .step_i     (lin_step_q),
    .cur_next_o (ny)
  );

  tavsl_lane u_lane_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .cmd_i      (s_axis_tdata_i[3*VEL_W-1:2*VEL_W]),
    .step_i     (ang_step_q),
    .cur_next_o (nz)
  );

  tavsl_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (ctl.tick),
    .lin_x_i (nx),
    .lin_y_i (ny),
    .ang_z_i (nz),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o)
  );

  `TAVSL_ASSERT(a_tick_gives_result, ctl.tick |=> m_axis_tvalid_o, "tick without result")
  `TAVSL_ASSERT(a_cmd_no_result, ctl.load |=> !$rose(m_axis_tvalid_o), "command made a result")
  `TAVSL_ASSERT(a_stall_only_full, !s_axis_tready_o |-> m_axis_tvalid_o, "stall while empty")
  `TAVSL_ASSERT(a_one_kind, !(ctl.load && ctl.tick), "command and tick together")
  `TAVSL_ASSERT_ALWAYS(a_expire_on_tick, ctl.expire |-> ctl.tick, "timeout outside a tick")

endmodule

// ----- tb/three_axis_velocity_slew_limiter_core_test.sv -----
// Self-checking testbench for the velocity slew limiter: streamed requests checked against a predictor.
module three_axis_velocity_slew_limiter_core_test;
  import tavsl_pkg::*;

  typedef struct packed {
    logic mode;
    vel_t lin_x;
    vel_t lin_y;
    vel_t ang_z;
  } vel_request_t;

  typedef struct packed {
    vel_t lin_x;
    vel_t lin_y;
    vel_t ang_z;
  } vel_triplet_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;

  // predictor state
  logic [STEP_W-1:0] lin_step = LINEAR_STEP_RST;
  logic [STEP_W-1:0] ang_step = ANGULAR_STEP_RST;
  logic [CNT_W-1:0]  timeout_lim = TIMEOUT_RST;
  logic [CNT_W-1:0]  ticks_idle = '0;
  vel_triplet_t      target_vel = '0;
  vel_triplet_t      current_vel = '0;

  vel_request_t vel_requests[$];
  vel_triplet_t expected_vel[$];
  int           mismatches = 0;

  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int src_gap = 0;
  int snk_gap = 0;

  three_axis_velocity_slew_limiter_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 1000000);
    $display("three_axis_velocity_slew_limiter_core_test: errors");
    $finish;
  end

  function automatic vel_t slew_toward(vel_t tgt, vel_t cur, logic [STEP_W-1:0] step);
    int diff;
    int lim;
    diff = int'(tgt) - int'(cur);
    lim  = int'({17'd0, step});
    if (diff > lim) diff = lim;
    else if (diff < -lim) diff = -lim;
    return vel_t'(int'(cur) + diff);
  endfunction

  task automatic advance_limiter(input logic mode, input logic [TDATA_W-1:0] data);
    if (mode == MODE_CMD) begin
      target_vel = {data[15:0], data[31:16], data[47:32]};
      ticks_idle = '0;
    end else begin
      if (ticks_idle != '1) ticks_idle++;
      if (ticks_idle > timeout_lim) target_vel = '0;
      current_vel.lin_x = slew_toward(target_vel.lin_x, current_vel.lin_x, lin_step);
      current_vel.lin_y = slew_toward(target_vel.lin_y, current_vel.lin_y, lin_step);
      current_vel.ang_z = slew_toward(target_vel.ang_z, current_vel.ang_z, ang_step);
      expected_vel.push_back(current_vel);
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    vel_request_t nxt;
    if (rst_ni && (!s_tvalid || s_tready)) begin
      if (src_gap != 0) begin
        src_gap  <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (vel_requests.size() != 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          src_gap  <= $urandom_range(0, 9);
          s_tvalid <= 1'b0;
        end else begin
          nxt = vel_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.mode;
          s_tdata  <= {nxt.ang_z, nxt.lin_y, nxt.lin_x};
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and a long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_left <= 400;
        hold_seen <= hold_seen + 1;
        m_tready  <= 1'b0;
      end else if (snk_gap != 0) begin
        snk_gap  <= snk_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        snk_gap  <= $urandom_range(0, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // monitor: check results, then predict from accepted requests
  always @(posedge clk_i) begin
    vel_triplet_t got;
    vel_triplet_t exp_v;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32]};
        if (expected_vel.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h", m_tdata);
          mismatches++;
        end else begin
          exp_v = expected_vel.pop_front();
          if (got !== exp_v) begin
            if (mismatches < 10)
              $display("result mismatch: exp x %0d y %0d z %0d, got x %0d y %0d z %0d",
                       exp_v.lin_x, exp_v.lin_y, exp_v.ang_z,
                       got.lin_x, got.lin_y, got.ang_z);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) advance_limiter(s_tuser, s_tdata);
    end
  end

  function automatic vel_t rand_vel();
    case ($urandom_range(0, 7))
      0: return vel_t'(16'h7FFF);
      1: return vel_t'(16'h8000);
      2: return '0;
      3: return vel_t'($urandom_range(0, 400)) - vel_t'(200);
      default: return vel_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_step();
    logic [STEP_W-1:0] s;
    case ($urandom_range(0, 5))
      0: s = '0;
      1: s = '1;
      2: s = STEP_W'(1);
      3: s = STEP_W'($urandom_range(1, 200));
      4: s = STEP_W'($urandom_range(200, 4000));
      default: s = STEP_W'($urandom);
    endcase
    return {1'($urandom_range(0, 1)), s};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_timeout();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_DATA_W'(1);
      2: return '1;
      3: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(2, 8));
    endcase
  endfunction

  task automatic push_cmd(input vel_t x, input vel_t y, input vel_t z);
    vel_requests.push_back('{MODE_CMD, x, y, z});
  endtask

  task automatic push_tick();
    vel_requests.push_back('{MODE_TICK, vel_t'($urandom), vel_t'($urandom), vel_t'($urandom)});
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_LINEAR_STEP:  lin_step = val[STEP_W-1:0];
      CFG_ANGULAR_STEP: ang_step = val[STEP_W-1:0];
      CFG_TIMEOUT:      timeout_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [CFG_DATA_W-1:0] lin, input logic [CFG_DATA_W-1:0] ang,
                            input logic [CFG_DATA_W-1:0] tmo);
    write_reg(CFG_LINEAR_STEP, lin);
    write_reg(CFG_ANGULAR_STEP, ang);
    write_reg(CFG_TIMEOUT, tmo);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (vel_requests.size() != 0 || s_tvalid || expected_vel.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(input int n, input bit hold_off, input bit calm);
    int cnt;
    int k;
    cnt = 0;
    @(negedge clk_i);
    quiet = calm;
    if (hold_off) hold_req++;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 8) begin
        push_cmd(rand_vel(), rand_vel(), rand_vel());
        k = $urandom_range(1, 8);
        repeat (k) push_tick();
        cnt += k + 1;
      end else begin
        if ($urandom_range(0, 1) == 0) push_tick();
        else push_cmd(rand_vel(), rand_vel(), rand_vel());
        cnt++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset limits: tick before any command, exact steps, timeout expiry
    @(negedge clk_i);
    vel_requests.push_back('{MODE_TICK, vel_t'(16'hFFFF), vel_t'(16'hFFFF), vel_t'(16'hFFFF)});
    push_cmd(vel_t'(51), vel_t'(-51), vel_t'(102));
    push_tick();
    push_cmd(vel_t'(52), vel_t'(-52), vel_t'(103));
    push_tick();
    push_cmd(vel_t'(16'h7FFF), vel_t'(16'h8000), vel_t'(16'h7FFF));
    repeat (5) push_tick();
    drain();

    // zero linear step, widest angular step, timeout zero
    set_limits(16'h0000, 16'hFFFF, 16'h0000);
    @(negedge clk_i);
    push_cmd(vel_t'(16'h8000), vel_t'(16'h7FFF), vel_t'(16'h8000));
    repeat (2) push_tick();
    push_cmd('0, '0, '0);
    push_tick();
    drain();

    // widest linear step, zero angular step, largest timeout
    set_limits(16'h7FFF, 16'h8000, 16'hFFFF);
    @(negedge clk_i);
    push_cmd(vel_t'(16'h7FFF), vel_t'(16'h8000), vel_t'(16'h7FFF));
    repeat (2) push_tick();
    push_cmd(vel_t'(16'h8000), vel_t'(16'h7FFF), vel_t'(16'h8000));
    push_tick();
    drain();

    for (int p = 0; p < 8; p++) begin
      set_limits(rand_step(), rand_step(), rand_timeout());
      run_phase(150, p == 3, p == 7);
    end

    if (mismatches == 0 && expected_vel.size() == 0) begin
      $display("three_axis_velocity_slew_limiter_core_test: clean");
    end else begin
      $display("three_axis_velocity_slew_limiter_core_test: errors");
    end
    $finish;
  end

endmodule
